>>> rtl/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Shared widths, register indexes and the result tag of the pooling unit.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned SUM_W        = 22;
  localparam int unsigned ROW_W        = 8;
  localparam int unsigned COL_W        = 8;
  localparam int unsigned CH_W         = 6;
  localparam int unsigned K_W          = 4;
  localparam int unsigned WIN_W        = 3;
  localparam int unsigned DIM_W        = 9;
  localparam int unsigned CHN_W        = 7;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned IDX_W        = 2;
  localparam int unsigned ADDR_W       = COL_W + CH_W;
  localparam int unsigned SUM_DEPTH    = 1 << ADDR_W;
  localparam int unsigned MAX_KERNEL   = 8;
  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned RECIP_W      = 29;
  localparam int unsigned RECIP_SHIFT  = 28;

  typedef enum logic [IDX_W-1:0] {
    REG_KERNEL = 2'd0,
    REG_ROWS   = 2'd1,
    REG_COLS   = 2'd2,
    REG_CHANS  = 2'd3
  } apf_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  ch;
    logic             last;
  } apf_meta_t;

endpackage

>>> rtl/average_pooling_forward_unit.sv
// ----------------------------------------------------------------------------
// average_pooling_forward_unit
// Non-overlapping 2-D average pooling of a raster-order Q8.8 sample stream.
// ----------------------------------------------------------------------------
// Takes one sample per clock. Partial sums sit in one 16384 x 22-bit memory
// addressed by pooled column and channel; each sample is a read at accept and
// an add and write-back in the registered stage after it, with the last write
// forwarded when the same entry comes round again at once. A window's pooled
// word goes from that stage through a three-stage rounding divider and an
// output register to the output. Input is held off only while that output
// word waits. The memory needs no clearing pass after reset. Any register
// write restarts the frame; write registers only while the unit is idle.
module average_pooling_forward_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [apf_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [apf_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [15:0]                        s_axis_tdata,  // sample[15:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // average[15:0], out_row[23:16], out_col[31:24], out_channel[37:32], zero
  output logic [39:0]                        m_axis_tdata,
  output logic                               m_axis_tlast   // frame_last
);
  import apf_pkg::*;

  // configuration
  logic [K_W-1:0]   k_cfg_q;
  logic [DIM_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [CHN_W-1:0] chans_cfg_q;
  logic [K_W-1:0]   k;
  logic [DIM_W-1:0] rows, cols;
  logic [CHN_W-1:0] chans;
  logic [WIN_W-1:0] k_m1;

  // position counters
  logic [ROW_W-1:0] row_q, row_d, row_base_q, row_base_d, orow_q, orow_d;
  logic [COL_W-1:0] col_q, col_d, col_base_q, col_base_d, ocol_q, ocol_d;
  logic [CH_W-1:0]  ch_q, ch_d;
  logic [WIN_W-1:0] rw_q, rw_d, cw_q, cw_d;

  logic             en, acc;
  logic             ch_last, col_last, row_last, cw_last, rw_last;
  logic             row_fit, col_fit, row_end, col_end;
  logic [ADDR_W-1:0] addr;

  // read-modify-write stage
  logic                    s1_valid_q, s1_first_q, s1_fit_q, s1_emit_q;
  logic [SAMPLE_W-1:0]     s1_sample_q;
  logic [ADDR_W-1:0]       s1_addr_q, wr_addr_q;
  apf_meta_t               s1_meta_q, cur_meta;
  logic [SUM_W-1:0]        rd_q, wr_data_q, base, s1_sum;
  logic                    wr_en;
  logic [SUM_W-1:0]        sum_mem [SUM_DEPTH];

  logic                    div_valid;
  logic [SAMPLE_W-1:0]     div_avg;
  apf_meta_t               div_meta;
  logic                    out_valid_q;
  logic [SAMPLE_W-1:0]     out_avg_q;
  apf_meta_t               out_meta_q;

  always_comb begin
    if (k_cfg_q == '0) begin
      k = K_W'(1);
    end else if (k_cfg_q > K_W'(MAX_KERNEL)) begin
      k = K_W'(MAX_KERNEL);
    end else begin
      k = k_cfg_q;
    end
    if (rows_cfg_q == '0) begin
      rows = DIM_W'(1);
    end else if (rows_cfg_q > DIM_W'(MAX_DIM)) begin
      rows = DIM_W'(MAX_DIM);
    end else begin
      rows = rows_cfg_q;
    end
    if (cols_cfg_q == '0) begin
      cols = DIM_W'(1);
    end else if (cols_cfg_q > DIM_W'(MAX_DIM)) begin
      cols = DIM_W'(MAX_DIM);
    end else begin
      cols = cols_cfg_q;
    end
    if (chans_cfg_q == '0) begin
      chans = CHN_W'(1);
    end else if (chans_cfg_q > CHN_W'(MAX_CHANNELS)) begin
      chans = CHN_W'(MAX_CHANNELS);
    end else begin
      chans = chans_cfg_q;
    end
  end

  assign k_m1 = WIN_W'(k - K_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q     <= K_W'(2);
      rows_cfg_q  <= DIM_W'(MAX_DIM);
      cols_cfg_q  <= DIM_W'(MAX_DIM);
      chans_cfg_q <= CHN_W'(1);
    end else if (cfg_we_i) begin
      unique case (apf_reg_e'(cfg_index_i))
        REG_KERNEL: k_cfg_q     <= cfg_wdata_i[K_W-1:0];
        REG_ROWS:   rows_cfg_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_COLS:   cols_cfg_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_CHANS:  chans_cfg_q <= cfg_wdata_i[CHN_W-1:0];
      endcase
    end
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  assign ch_last  = {1'b0, ch_q} == chans - CHN_W'(1);
  assign col_last = {1'b0, col_q} == cols - DIM_W'(1);
  assign row_last = {1'b0, row_q} == rows - DIM_W'(1);
  assign cw_last  = cw_q == k_m1;
  assign rw_last  = rw_q == k_m1;

  // window is whole when base + k <= dim; last window when base + 2k > dim
  assign row_fit = ({2'b0, row_base_q} + 10'(k)) <= {1'b0, rows};
  assign col_fit = ({2'b0, col_base_q} + 10'(k)) <= {1'b0, cols};
  assign row_end = ({2'b0, row_base_q} + 10'({k, 1'b0})) > {1'b0, rows};
  assign col_end = ({2'b0, col_base_q} + 10'({k, 1'b0})) > {1'b0, cols};

  assign addr          = {ocol_q, ch_q};
  assign cur_meta.row  = orow_q;
  assign cur_meta.col  = ocol_q;
  assign cur_meta.ch   = ch_q;
  assign cur_meta.last = row_end && col_end && ch_last;

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    ch_d       = ch_q;
    rw_d       = rw_q;
    cw_d       = cw_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    row_base_d = row_base_q;
    col_base_d = col_base_q;
    if (cfg_we_i) begin
      row_d      = '0;
      col_d      = '0;
      ch_d       = '0;
      rw_d       = '0;
      cw_d       = '0;
      orow_d     = '0;
      ocol_d     = '0;
      row_base_d = '0;
      col_base_d = '0;
    end else if (acc) begin
      ch_d = ch_q + CH_W'(1);
      if (ch_last) begin
        ch_d = '0;
        if (col_last) begin
          col_d      = '0;
          cw_d       = '0;
          ocol_d     = '0;
          col_base_d = '0;
          if (row_last) begin
            row_d      = '0;
            rw_d       = '0;
            orow_d     = '0;
            row_base_d = '0;
          end else begin
            row_d = row_q + ROW_W'(1);
            if (rw_last) begin
              rw_d       = '0;
              orow_d     = orow_q + ROW_W'(1);
              row_base_d = row_base_q + ROW_W'(k);
            end else begin
              rw_d = rw_q + WIN_W'(1);
            end
          end
        end else begin
          col_d = col_q + COL_W'(1);
          if (cw_last) begin
            cw_d       = '0;
            ocol_d     = ocol_q + COL_W'(1);
            col_base_d = col_base_q + COL_W'(k);
          end else begin
            cw_d = cw_q + WIN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      ch_q       <= '0;
      rw_q       <= '0;
      cw_q       <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
      row_base_q <= '0;
      col_base_q <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      ch_q       <= ch_d;
      rw_q       <= rw_d;
      cw_q       <= cw_d;
      orow_q     <= orow_d;
      ocol_q     <= ocol_d;
      row_base_q <= row_base_d;
      col_base_q <= col_base_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= acc;
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      s1_addr_q   <= addr;
      s1_first_q  <= (rw_q == '0) && (cw_q == '0);
      s1_fit_q    <= row_fit && col_fit;
      s1_emit_q   <= rw_last && cw_last;
      s1_meta_q   <= cur_meta;
    end
    if (wr_en) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= s1_sum;
    end
    if (en) begin
      out_avg_q  <= div_avg;
      out_meta_q <= div_meta;
    end
  end

  // last write is not yet visible to a read issued on the same edge
  assign base   = s1_first_q ? '0 : ((wr_addr_q == s1_addr_q) ? wr_data_q : rd_q);
  assign s1_sum = base + {{(SUM_W-SAMPLE_W){s1_sample_q[SAMPLE_W-1]}}, s1_sample_q};
  assign wr_en  = en && s1_valid_q && s1_fit_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= sum_mem[addr];
    end
    if (wr_en) begin
      sum_mem[s1_addr_q] <= s1_sum;
    end
  end

  apf_round_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s1_valid_q && s1_fit_q && s1_emit_q),
    .sum_i    (s1_sum),
    .meta_i   (s1_meta_q),
    .kernel_i (k),
    .valid_o  (div_valid),
    .avg_o    (div_avg),
    .meta_o   (div_meta)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_meta_q.ch, out_meta_q.col, out_meta_q.row, out_avg_q};
  assign m_axis_tlast  = out_meta_q.last;

  a_cw_in_kernel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cw_q} < k && {1'b0, rw_q} < k)
    else $error("window position beyond kernel");

  a_ch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ch_q} < chans)
    else $error("channel counter beyond channel count");

  a_base_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_base_q <= col_q && row_base_q <= row_q)
    else $error("window base ahead of position");

  a_wr_follows_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(acc || !en))
    else $error("sum write without an accepted word");

endmodule

>>> rtl/apf_round_div.sv
// ----------------------------------------------------------------------------
// apf_round_div
// Divides a window sum by kernel squared, nearest, ties away from zero.
// Three stages: magnitude plus half, reciprocal multiply, sign restore.
// ----------------------------------------------------------------------------
module apf_round_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [apf_pkg::SUM_W-1:0]    sum_i,
  input  apf_pkg::apf_meta_t                  meta_i,
  input  logic [apf_pkg::K_W-1:0]             kernel_i,
  output logic                                valid_o,
  output logic [apf_pkg::SAMPLE_W-1:0]        avg_o,
  output apf_pkg::apf_meta_t                  meta_o
);
  import apf_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  // ceil(2^28 / k^2): exact floor for every 22-bit dividend
  function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      4'd2:    r = 29'd67108864;
      4'd3:    r = 29'd29826162;
      4'd4:    r = 29'd16777216;
      4'd5:    r = 29'd10737419;
      4'd6:    r = 29'd7456541;
      4'd7:    r = 29'd5478275;
      4'd8:    r = 29'd4194304;
      default: r = 29'd268435456;
    endcase
    return r;
  endfunction

  logic                    a_valid_q, b_valid_q, c_valid_q;
  logic signed [SUM_W-1:0] a_sum_q;
  apf_meta_t               a_meta_q, b_meta_q, c_meta_q;
  logic [SUM_W-1:0]        b_mag_q;
  logic                    b_neg_q, c_neg_q;
  logic [PROD_W-1:0]       c_prod_q;

  logic [7:0]              kk;
  logic [SUM_W-1:0]        abs_sum;
  logic [SUM_W-1:0]        mag_d;
  logic [PROD_W-1:0]       prod_d;
  logic [SAMPLE_W-1:0]     quot;

  assign kk      = 8'(kernel_i) * 8'(kernel_i);
  assign abs_sum = a_sum_q[SUM_W-1] ? (~a_sum_q + SUM_W'(1)) : a_sum_q;
  assign mag_d   = abs_sum + SUM_W'(kk[7:1]);
  assign prod_d  = PROD_W'(b_mag_q) * PROD_W'(recip(kernel_i));
  assign quot    = c_prod_q[RECIP_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sum_q  <= sum_i;
      a_meta_q <= meta_i;
      b_mag_q  <= mag_d;
      b_neg_q  <= a_sum_q[SUM_W-1];
      b_meta_q <= a_meta_q;
      c_prod_q <= prod_d;
      c_neg_q  <= b_neg_q;
      c_meta_q <= b_meta_q;
    end
  end

  assign valid_o = c_valid_q;
  assign avg_o   = c_neg_q ? (~quot + SAMPLE_W'(1)) : quot;
  assign meta_o  = c_meta_q;

endmodule

>>> tb/avg_pool_checker.sv
// ----------------------------------------------------------------------------
// avg_pool_checker
// Follows register writes and accepted samples, keeps its own window sums and
// frame position, predicts each pooled word and compares it, field by field,
// with the oldest word still expected when the unit hands one over.
// ----------------------------------------------------------------------------
module avg_pool_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [apf_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [apf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [15:0]               in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [39:0]               out_data_i,
  input  logic                      out_last_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        checked_o
);
  import apf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    apf_meta_t                  meta;
  } pooled_word_t;

  pooled_word_t     pooled_q[$];

  logic [K_W-1:0]   kernel_r;
  logic [DIM_W-1:0] rows_r;
  logic [DIM_W-1:0] cols_r;
  logic [CHN_W-1:0] chans_r;

  int               sums [SUM_DEPTH];
  int unsigned      row_n, col_n, ch_n, row_in_win, col_in_win;
  int               errors, checked;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // nearest, ties away from zero
  function automatic logic signed [SAMPLE_W-1:0] round_mean(int s, int kk);
    int mag, q;
    mag = (s < 0) ? -s : s;
    q   = (mag + kk / 2) / kk;
    return SAMPLE_W'((s < 0) ? -q : q);
  endfunction

  task automatic restart_frame();
    row_n      = 0;
    col_n      = 0;
    ch_n       = 0;
    row_in_win = 0;
    col_in_win = 0;
  endtask

  task automatic pool_sample(logic signed [SAMPLE_W-1:0] x);
    int unsigned  k, rows, cols, chans, orow, ocol, addr;
    pooled_word_t w;
    k     = clamp_dim(kernel_r, MAX_KERNEL);
    rows  = clamp_dim(rows_r, MAX_DIM);
    cols  = clamp_dim(cols_r, MAX_DIM);
    chans = clamp_dim(chans_r, MAX_CHANNELS);
    orow  = row_n / k;
    ocol  = col_n / k;
    if (orow < rows / k && ocol < cols / k) begin
      addr = ocol * MAX_CHANNELS + ch_n;
      if (row_in_win == 0 && col_in_win == 0) sums[addr] = int'(x);
      else sums[addr] += int'(x);
      if (row_in_win == k - 1 && col_in_win == k - 1) begin
        w.average   = round_mean(sums[addr], k * k);
        w.meta.row  = ROW_W'(orow);
        w.meta.col  = COL_W'(ocol);
        w.meta.ch   = CH_W'(ch_n);
        w.meta.last = (orow == rows / k - 1) && (ocol == cols / k - 1) &&
                      (ch_n == chans - 1);
        pooled_q = {pooled_q, w};
      end
    end
    ch_n++;
    if (ch_n >= chans) begin
      ch_n = 0;
      col_n++;
      col_in_win++;
      if (col_in_win >= k) col_in_win = 0;
      if (col_n >= cols) begin
        col_n      = 0;
        col_in_win = 0;
        row_n++;
        row_in_win++;
        if (row_in_win >= k) row_in_win = 0;
        if (row_n >= rows) begin
          row_n      = 0;
          row_in_win = 0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_word_t got, want;
    if (!rst_ni) begin
      kernel_r = K_W'(2);
      rows_r   = DIM_W'(256);
      cols_r   = DIM_W'(256);
      chans_r  = CHN_W'(1);
      restart_frame();
      pooled_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.average   = out_data_i[15:0];
        got.meta.row  = out_data_i[23:16];
        got.meta.col  = out_data_i[31:24];
        got.meta.ch   = out_data_i[37:32];
        got.meta.last = out_last_i;
        if (pooled_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected pooled word: avg %0d row %0d col %0d ch %0d last %0b",
                     got.average, got.meta.row, got.meta.col, got.meta.ch, got.meta.last);
        end else begin
          want = pooled_q.pop_front();
          checked++;
          if (got.average !== want.average || got.meta.row !== want.meta.row ||
              got.meta.col !== want.meta.col || got.meta.ch !== want.meta.ch ||
              got.meta.last !== want.meta.last) begin
            errors++;
            if (errors <= 10) begin
              $display("pooled word mismatch: want avg %0d row %0d col %0d ch %0d last %0b",
                       want.average, want.meta.row, want.meta.col, want.meta.ch,
                       want.meta.last);
              $display("                       got avg %0d row %0d col %0d ch %0d last %0b",
                       got.average, got.meta.row, got.meta.col, got.meta.ch,
                       got.meta.last);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (apf_reg_e'(cfg_index_i))
          REG_KERNEL: kernel_r = cfg_wdata_i[K_W-1:0];
          REG_ROWS:   rows_r   = cfg_wdata_i[DIM_W-1:0];
          REG_COLS:   cols_r   = cfg_wdata_i[DIM_W-1:0];
          REG_CHANS:  chans_r  = cfg_wdata_i[CHN_W-1:0];
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid_i && in_ready_i) pool_sample(in_data_i);
    end
    errors_o  <= errors;
    pending_o <= pooled_q.size();
    checked_o <= checked;
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives register settings and sample streams into the pooling unit, with
// random gaps on both sides, and reports the verdict of the word checker.
// ----------------------------------------------------------------------------
module tb;
  import apf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;

  // 2 x 2 windows: both extremes, then half-way ties either side of zero
  localparam logic [15:0] CORNER_WORDS [16] = '{
    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
    16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h0002, 16'h0000, 16'h0000, 16'h0000,
    16'hfffe, 16'h0000, 16'h0000, 16'h0000
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata   = '0;   // sample[15:0]
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [39:0]      m_tdata;          // average, out_row, out_col, out_channel
  logic             m_tlast;          // frame_last
  logic             gaps_on   = 1'b1;

  int               errors, pending, checked;
  int unsigned      samples_sent = 0;
  int unsigned      phases = 0;

  average_pooling_forward_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  avg_pool_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .out_last_i  (m_tlast),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(0, 99) >= 12);
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1:       return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_sample(logic [15:0] value);
    if (gaps_on && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // wait for every expected word, then for the pipeline to empty
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_map(int unsigned k, int unsigned rows,
                          int unsigned cols, int unsigned chans);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_KERNEL;
    cfg_wdata <= CFG_W'(k);
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_CHANS;
    cfg_wdata <= CFG_W'(chans);
    @(posedge clk);
    cfg_we    <= 1'b0;
    phases++;
  endtask

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned k, rows, cols, chans, frame_len, target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset map is 256 x 256: no window closes, the next write restarts it
    repeat (3) push_sample(rand_sample());
    load_map(2, 2, 2, 1);
    foreach (CORNER_WORDS[i]) push_sample(CORNER_WORDS[i]);
    // zero kernel and dimensions act as one
    load_map(0, 0, 0, 0);
    push_sample(16'h8000);
    push_sample(16'h7fff);
    // kernel wider than the map: nothing comes out
    load_map(5, 3, 3, 1);
    repeat (4) push_sample(rand_sample());

    // oversized settings clamp; full row and channel index ranges
    load_map(15, 8, 8, 1);
    repeat (64) push_sample(rand_sample());
    gaps_on <= 1'b0;
    load_map(1, 511, 1, 1);
    repeat (256) push_sample(rand_sample());
    gaps_on <= 1'b1;
    load_map(1, 1, 1, 127);
    repeat (64) push_sample(rand_sample());

    target = samples_sent + 40;
    while (samples_sent < target) begin
      k    = $urandom_range(1, 4);
      rows = k * $urandom_range(1, 2) + $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0) rows = $urandom_range(1, k);
      cols  = k * $urandom_range(1, 3) + $urandom_range(0, 1);
      chans = (k > 2) ? $urandom_range(1, 2) : $urandom_range(1, 4);
      frame_len = rows * cols * chans;
      gaps_on <= ($urandom_range(0, 3) != 0);
      load_map(((k == 1) && $urandom_range(0, 1)) ? 0 : k, rows, cols,
               ((chans == 1) && $urandom_range(0, 1)) ? 0 : chans);
      repeat (frame_len * $urandom_range(1, 2)) push_sample(rand_sample());
      // cut a frame short now and then
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, frame_len)) push_sample(rand_sample());
    end

    drain();
    $display("sent %0d samples over %0d register settings, %0d pooled words checked",
             samples_sent, phases, checked);
    if (errors == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/apf_pkg.sv
rtl/apf_round_div.sv
rtl/average_pooling_forward_unit.sv
tb/avg_pool_checker.sv
tb/tb.sv
